[design/pbmi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pbmi_pkg;

  // fixed point format of the positions
  localparam int FRAC_BITS = 16;

  // shared alu geometry
  localparam int ALU_A_W   = 80;
  localparam int ALU_B_W   = 48;
  localparam int MUL_STEPS = 32;
  localparam int DIV_STEPS = ALU_A_W;
  localparam int ALU_CNT_W = $clog2(DIV_STEPS);

  localparam logic [30:0] FEED_MAX = 31'h7FFF_FFFF;
  localparam logic [32:0] MAG_CAP  = 33'h1_0000_0000;

  // opcodes
  localparam logic [31:0] CMD_STOP  = 32'd1;
  localparam logic [31:0] CMD_PAUSE = 32'd2;
  localparam logic [31:0] CMD_MOVEF = 32'd3;
  localparam logic [31:0] CMD_MOVEL = 32'd4;
  localparam logic [31:0] CMD_DELAY = 32'd5;
  localparam logic [31:0] CMD_PARAM = 32'd6;

  // parameter ids
  localparam logic [31:0] PARAM_NOZZLE = 32'h0000_0039;
  localparam logic [31:0] PARAM_BED    = 32'h0000_003B;

  // result kinds
  localparam logic [2:0] KIND_MOVE    = 3'd0;
  localparam logic [2:0] KIND_DWELL   = 3'd1;
  localparam logic [2:0] KIND_NOZZLE  = 3'd2;
  localparam logic [2:0] KIND_BED     = 3'd3;
  localparam logic [2:0] KIND_STOP    = 3'd4;
  localparam logic [2:0] KIND_PAUSE   = 3'd5;
  localparam logic [2:0] KIND_REPORT  = 3'd6;
  localparam logic [2:0] KIND_UNKNOWN = 3'd7;

  // axis mask bits
  localparam logic [3:0] AXM_X = 4'b0001;
  localparam logic [3:0] AXM_Y = 4'b0010;
  localparam logic [3:0] AXM_Z = 4'b0100;
  localparam logic [3:0] AXM_E = 4'b1000;
  localparam logic [3:0] AXM_MOVEL = AXM_X | AXM_Y | AXM_E;

  // register indexes
  localparam logic [2:0] REG_SPM_X    = 3'd0;
  localparam logic [2:0] REG_SPM_Y    = 3'd1;
  localparam logic [2:0] REG_SPM_E    = 3'd2;
  localparam logic [2:0] REG_Z_OFFSET = 3'd3;
  localparam logic [2:0] REG_TICK     = 3'd4;

  // axis slots of the ramp loop
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_E = 2'd2;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TRI,
    ST_MV,
    ST_MA,
    ST_QDIV,
    ST_CHECK,
    ST_D1,
    ST_D2,
    ST_FM,
    ST_FD,
    ST_FIN,
    ST_PUT
  } state_e;

  // magnitude of a single float times 2^frac, capped at 2^32
  function automatic logic [32:0] f_mag(input logic [31:0] w, input int frac,
                                        input logic rnd);
    logic [7:0]  e;
    logic [23:0] m;
    logic [32:0] v;
    logic [25:0] r;
    int          sh;
    int          n;
    e = w[30:23];
    m = {1'b0, w[22:0]};
    v = '0;
    r = '0;
    sh = 0;
    n = 0;
    f_mag = '0;
    if (e == 8'hFF) begin
      f_mag = (w[22:0] != 23'd0) ? 33'd0 : MAG_CAP;
    end else if (e != 8'd0 || w[22:0] != 23'd0) begin
      if (e == 8'd0) begin
        sh = 1 - 150 + frac;
      end else begin
        m[23] = 1'b1;
        sh = int'(e) - 150 + frac;
      end
      if (sh >= 9) begin
        f_mag = MAG_CAP;
      end else if (sh >= 0) begin
        v = 33'(m) << sh;
        f_mag = (v > MAG_CAP) ? MAG_CAP : v;
      end else begin
        n = -sh;
        if (n >= 25) begin
          f_mag = '0;
        end else if (rnd) begin
          r = 26'(m) + (26'd1 << (n - 1));
          f_mag = 33'(r >> n);
        end else begin
          f_mag = 33'(m >> n);
        end
      end
    end
  endfunction

  // float to fixed point, round to nearest, saturating
  function automatic logic signed [31:0] f_to_q(input logic [31:0] w);
    logic [32:0] mag;
    mag = f_mag(w, FRAC_BITS, 1'b1);
    if (w[31]) begin
      f_to_q = (mag > 33'h0_8000_0000) ? 32'sh8000_0000 : 32'(-mag);
    end else begin
      f_to_q = (mag > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(mag);
    end
  endfunction

  // float feed, truncated and saturated
  function automatic logic [30:0] f_to_feed(input logic [31:0] w);
    logic [32:0] mag;
    mag = f_mag(w, 0, 1'b0);
    f_to_feed = (mag > 33'(FEED_MAX)) ? FEED_MAX : mag[30:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sh0_7FFF_FFFF) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic [15:0] abs16(input logic [15:0] v);
    abs16 = v[15] ? 16'(-v) : v;
  endfunction

endpackage

`default_nettype wire

[design/pbmi_alu.sv]
`timescale 1ns / 1ps
`default_nettype none

module pbmi_alu
  import pbmi_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire alu_req_t             req_i,
  input  wire logic [ALU_A_W-1:0]   a_i,
  input  wire logic [ALU_B_W-1:0]   b_i,
  output logic                      done_o,
  output logic [ALU_A_W-1:0]        res_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  alu_op_e              op_q, op_d;
  logic [ALU_CNT_W-1:0] cnt_q, cnt_d;
  logic [ALU_B_W:0]     r_q, r_d;
  logic [ALU_A_W-1:0]   w_q, w_d;
  logic [ALU_B_W-1:0]   opnd_q, opnd_d;

  logic [ALU_B_W:0]     sum;
  logic [ALU_B_W:0]     trial;
  logic                 fits;
  logic [ALU_CNT_W-1:0] last;

  always_comb begin
    // multiply: add then shift right, product bits enter w from the top
    sum   = {1'b0, r_q[ALU_B_W-1:0]} + (w_q[0] ? {1'b0, opnd_q} : '0);
    // divide: restoring, one quotient bit a step
    trial = {r_q[ALU_B_W-1:0], w_q[ALU_A_W-1]};
    fits  = trial >= {1'b0, opnd_q};
    last  = (op_q == ALU_MUL) ? ALU_CNT_W'(MUL_STEPS - 1) : ALU_CNT_W'(DIV_STEPS - 1);

    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    r_d    = r_q;
    w_d    = w_q;
    opnd_d = opnd_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = '0;
      r_d    = '0;
      if (req_i.op == ALU_MUL) begin
        w_d    = ALU_A_W'(b_i[MUL_STEPS-1:0]);
        opnd_d = a_i[ALU_B_W-1:0];
      end else begin
        w_d    = a_i;
        opnd_d = b_i;
      end
    end else if (busy_q) begin
      if (op_q == ALU_MUL) begin
        r_d = {1'b0, sum[ALU_B_W:1]};
        w_d = {sum[0], w_q[ALU_A_W-1:1]};
      end else begin
        r_d = fits ? (trial - {1'b0, opnd_q}) : trial;
        w_d = {w_q[ALU_A_W-2:0], fits};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    cnt_q  <= cnt_d;
    r_q    <= r_d;
    w_q    <= w_d;
    opnd_q <= opnd_d;
  end

  assign done_o = done_q;
  assign res_o  = (op_q == ALU_MUL) ?
                  {r_q[ALU_B_W-1:0], w_q[ALU_A_W-1:ALU_A_W-MUL_STEPS]} : w_q;

endmodule

`default_nettype wire

[design/print_block_motion_interpreter.sv]
`timescale 1ns / 1ps
`default_nettype none

// Print program block interpreter. Each input word is one program block
// (opcode plus four raw data words); each block gives at most one result
// word on the output channel. The block keeps X, Y, Z and E in signed
// Q16.16 mm, the last reported feed and the MoveF half toggle. MoveL
// runs its multiplies and divides on one shared iterative unit. The input
// is not ready while a block is worked on; a finished result waits in
// the output register while the next block is already taken in.
// Configuration registers are written by index with no handshake.

module print_block_motion_interpreter
  import pbmi_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  // block input
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [31:0]        command_i,
  input  wire logic [31:0]        word_one_i,
  input  wire logic [31:0]        word_two_i,
  input  wire logic [31:0]        word_three_i,
  input  wire logic [31:0]        word_four_i,
  // result output
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [2:0]              kind_o,
  output logic signed [31:0]      out_x_o,
  output logic signed [31:0]      out_y_o,
  output logic signed [31:0]      out_z_o,
  output logic signed [31:0]      out_e_o,
  output logic [3:0]              axis_mask_o,
  output logic [30:0]             feed_o,
  output logic                    has_feed_o,
  output logic [31:0]             code_o,
  output logic [31:0]             value_o
);

  // configuration registers
  logic [15:0]        spm_x_q, spm_y_q, spm_e_q;
  logic signed [31:0] z_off_q;
  logic [31:0]        tick_q;

  // interpreter state
  logic signed [31:0] pos_x_q, pos_y_q, pos_z_q, pos_e_q;
  logic [31:0]        last_feed_q;
  logic [30:0]        mfs_q;
  logic [3:0]         flags_q;
  logic               xy_half_q;

  // sequencer
  state_e     state_q, state_d;
  logic       issued_q;
  logic [1:0] ax_q;

  // latched block
  logic [31:0] cmd_q, w1_q, w2_q, w3_q, w4_q;

  // ramp work registers
  logic [30:0]        tri_q;
  logic [30:0]        p1_q;
  logic signed [39:0] sx_q, sy_q, se_q;
  logic [31:0]        tmp_q;
  logic [47:0]        d_q;
  logic [30:0]        fmax_q;

  // pending result
  logic [2:0]  res_kind_q;
  logic [3:0]  res_mask_q;
  logic [30:0] res_feed_q;
  logic        res_has_q;
  logic [31:0] res_code_q, res_value_q;
  logic        res_move_q;

  logic out_valid_q;
  logic slot_free;

  // shared unit
  alu_req_t            alu_req;
  logic [ALU_A_W-1:0]  alu_a;
  logic [ALU_B_W-1:0]  alu_b;
  logic                alu_done;
  logic [ALU_A_W-1:0]  alu_res;

  pbmi_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  assign slot_free = !out_valid_q || out_ready_i;

  // block fields
  logic [15:0] cnt_n, per;
  assign cnt_n = w1_q[15:0];
  assign per   = w1_q[31:16];

  // per-axis selection for the ramp loop
  logic [15:0]        v_sel, a_sel, spm_sel;
  logic signed [39:0] st_sel;
  logic signed [31:0] pos_sel;
  logic [39:0]        st_mag;
  logic [47:0]        a60;

  always_comb begin
    unique case (ax_q)
      AX_X: begin
        v_sel = w2_q[15:0];   a_sel = w3_q[31:16];
        spm_sel = spm_x_q;    st_sel = sx_q;  pos_sel = pos_x_q;
      end
      AX_Y: begin
        v_sel = w2_q[31:16];  a_sel = w4_q[15:0];
        spm_sel = spm_y_q;    st_sel = sy_q;  pos_sel = pos_y_q;
      end
      default: begin
        v_sel = w3_q[15:0];   a_sel = w4_q[31:16];
        spm_sel = spm_e_q;    st_sel = se_q;  pos_sel = pos_e_q;
      end
    endcase
    // zero steps per mm counts as one
    if (spm_sel == 16'd0) spm_sel = 16'd1;
    st_mag = st_sel[39] ? 40'(-st_sel) : 40'(st_sel);
    // times 60 as two shifts
    a60 = (48'(st_mag) << 6) - (48'(st_mag) << 2);
  end

  // ramp sum: sign-fixed partial products, floor over 512
  logic [48:0]        t1, t2, num;
  logic signed [39:0] steps_new;
  always_comb begin
    t1 = 49'(p1_q);
    t2 = 49'(alu_res[46:0]);
    num = (v_sel[15] ? -t1 : t1) + (a_sel[15] ? -t2 : t2);
    steps_new = num[48:9];
  end

  // quotient of the step conversion applied to the position
  logic [33:0]        qc;
  logic signed [35:0] delta;
  logic signed [31:0] pos_new;
  always_comb begin
    qc = (alu_res[ALU_A_W-1:33] != '0) ? 34'h2_0000_0000 : alu_res[33:0];
    delta = st_sel[39] ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
    pos_new = sat32({{4{pos_sel[31]}}, pos_sel} + delta);
  end

  // saturated feed of one axis
  logic [30:0] feed_ax;
  assign feed_ax = (alu_res[ALU_A_W-1:31] != '0) ? FEED_MAX : alu_res[30:0];

  // MoveF half
  logic               nz1, nz3, nan1, nan3, neg3;
  logic [30:0]        f1, f3;
  logic signed [31:0] q2, q4;
  logic [3:0]         mf_flags;
  logic [30:0]        mf_max;
  logic signed [31:0] mf_px, mf_py, mf_pz, mf_pe;
  always_comb begin
    nz1  = w1_q[30:0] != 31'd0;
    nz3  = w3_q[30:0] != 31'd0;
    nan1 = (w1_q[30:23] == 8'hFF) && (w1_q[22:0] != 23'd0);
    nan3 = (w3_q[30:23] == 8'hFF) && (w3_q[22:0] != 23'd0);
    neg3 = w3_q[31] && nz3 && !nan3;
    f1 = f_to_feed(w1_q);
    f3 = f_to_feed(w3_q);
    q2 = f_to_q(w2_q);
    q4 = f_to_q(w4_q);
    mf_flags = xy_half_q ? 4'd0 : flags_q;
    mf_max   = xy_half_q ? 31'd0 : mfs_q;
    mf_px = pos_x_q;  mf_py = pos_y_q;  mf_pz = pos_z_q;  mf_pe = pos_e_q;
    if (nz1) begin
      if (xy_half_q) mf_px = q2;
      else           mf_pz = q2;
      if (!nan1 && f1 > mf_max) mf_max = f1;
      mf_flags = mf_flags | (xy_half_q ? AXM_X : AXM_Z);
    end
    if (nz3) begin
      if (xy_half_q) mf_py = q4;
      else if (neg3) mf_pe = q4;
      else           mf_pe = sat32({{4{pos_e_q[31]}}, pos_e_q} + {{4{q4[31]}}, q4});
      if (!nan3 && f3 > mf_max) mf_max = f3;
      mf_flags = mf_flags | (xy_half_q ? AXM_Y : AXM_E);
    end
  end

  logic mf_result;
  assign mf_result = !xy_half_q && (mf_flags != 4'd0);

  logic steps_all_zero;
  assign steps_all_zero = (sx_q == '0) && (sy_q == '0) && (se_q == '0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_DECODE;
      ST_DECODE: begin
        if (cmd_q == CMD_MOVEL)      state_d = ST_TRI;
        else if (cmd_q == CMD_MOVEF) state_d = mf_result ? ST_PUT : ST_IDLE;
        else                         state_d = ST_PUT;
      end
      ST_TRI:  if (alu_done) state_d = ST_MV;
      ST_MV:   if (alu_done) state_d = ST_MA;
      ST_MA:   if (alu_done) state_d = ST_QDIV;
      ST_QDIV: if (alu_done) state_d = (ax_q == AX_E) ? ST_CHECK : ST_MV;
      ST_CHECK: begin
        if (steps_all_zero)                          state_d = ST_IDLE;
        else if (cnt_n < 16'd2 || per == 16'd0)      state_d = ST_PUT;
        else                                         state_d = ST_D1;
      end
      ST_D1:  if (alu_done) state_d = ST_D2;
      ST_D2:  if (alu_done) state_d = ST_FM;
      ST_FM:  if (alu_done) state_d = ST_FD;
      ST_FD:  if (alu_done) state_d = (ax_q == AX_E) ? ST_FIN : ST_D1;
      ST_FIN: state_d = ST_PUT;
      ST_PUT: if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake and shared unit operands
  always_comb begin
    in_ready_o    = 1'b0;
    alu_req.start = 1'b0;
    alu_req.op    = ALU_MUL;
    alu_a         = '0;
    alu_b         = '0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_TRI: begin
        alu_a = ALU_A_W'(cnt_n);
        alu_b = ALU_B_W'(16'(cnt_n - 16'd1));
      end
      ST_MV: begin
        alu_a = ALU_A_W'(abs16(v_sel));
        alu_b = ALU_B_W'(cnt_n);
      end
      ST_MA: begin
        alu_a = ALU_A_W'(abs16(a_sel));
        alu_b = ALU_B_W'(tri_q);
      end
      ST_QDIV: begin
        alu_req.op = ALU_DIV;
        alu_a = (ALU_A_W'(st_mag) << FRAC_BITS) + ALU_A_W'(spm_sel >> 1);
        alu_b = ALU_B_W'(spm_sel);
      end
      ST_D1: begin
        alu_a = ALU_A_W'(spm_sel);
        alu_b = ALU_B_W'(per);
      end
      ST_D2: begin
        alu_a = ALU_A_W'(tmp_q);
        alu_b = ALU_B_W'(cnt_n);
      end
      ST_FM: begin
        alu_a = ALU_A_W'(a60);
        alu_b = ALU_B_W'(tick_q);
      end
      ST_FD: begin
        // the product of the previous step still sits in the unit
        alu_req.op = ALU_DIV;
        alu_a = alu_res;
        alu_b = d_q;
      end
      default: ;
    endcase
    if ((state_q == ST_TRI) || (state_q == ST_MV) || (state_q == ST_MA) ||
        (state_q == ST_QDIV) || (state_q == ST_D1) || (state_q == ST_D2) ||
        (state_q == ST_FM) || (state_q == ST_FD)) begin
      alu_req.start = !issued_q;
    end
  end

  // feed reporting: only a changed feed is shown
  logic [30:0] rep_f;
  logic        rep_has;
  always_comb begin
    unique case (state_q)
      ST_DECODE: rep_f = mf_max;
      ST_CHECK:  rep_f = FEED_MAX;
      default:   rep_f = fmax_q;
    endcase
    rep_has = last_feed_q != {1'b0, rep_f};
  end

  // control state, positions and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      spm_x_q     <= 16'd854;
      spm_y_q     <= 16'd854;
      spm_e_q     <= 16'd854;
      z_off_q     <= 32'sd8067482;
      tick_q      <= 32'd50000000;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      pos_z_q     <= '0;
      pos_e_q     <= '0;
      last_feed_q <= '1;
      mfs_q       <= '0;
      flags_q     <= '0;
      xy_half_q   <= 1'b1;
    end else begin
      state_q <= state_d;
      if (alu_req.start)  issued_q <= 1'b1;
      else if (alu_done)  issued_q <= 1'b0;

      if (state_q == ST_PUT && slot_free) out_valid_q <= 1'b1;
      else if (out_ready_i)               out_valid_q <= 1'b0;

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_SPM_X:    spm_x_q <= cfg_data_i[15:0];
          REG_SPM_Y:    spm_y_q <= cfg_data_i[15:0];
          REG_SPM_E:    spm_e_q <= cfg_data_i[15:0];
          REG_Z_OFFSET: z_off_q <= cfg_data_i;
          REG_TICK:     tick_q  <= cfg_data_i;
          default: ;
        endcase
      end

      if (state_q == ST_DECODE && cmd_q == CMD_MOVEF) begin
        xy_half_q <= !xy_half_q;
        flags_q   <= mf_flags;
        mfs_q     <= mf_max;
        pos_x_q   <= mf_px;
        pos_y_q   <= mf_py;
        pos_z_q   <= mf_pz;
        pos_e_q   <= mf_pe;
        if (mf_result) last_feed_q <= {1'b0, mf_max};
      end

      if (state_q == ST_QDIV && alu_done) begin
        unique case (ax_q)
          AX_X:    pos_x_q <= pos_new;
          AX_Y:    pos_y_q <= pos_new;
          default: pos_e_q <= pos_new;
        endcase
      end

      if ((state_q == ST_CHECK && !steps_all_zero && cnt_n >= 16'd2 && per == 16'd0) ||
          state_q == ST_FIN) begin
        last_feed_q <= {1'b0, rep_f};
      end
    end
  end

  // payload and work registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= command_i;
      w1_q  <= word_one_i;
      w2_q  <= word_two_i;
      w3_q  <= word_three_i;
      w4_q  <= word_four_i;
    end

    unique case (state_q)
      ST_DECODE: begin
        ax_q   <= AX_X;
        fmax_q <= '0;
        case (cmd_q)
          CMD_STOP: begin
            res_kind_q  <= KIND_STOP;
            res_mask_q  <= '0;
            res_feed_q  <= '0;
            res_has_q   <= 1'b0;
            res_move_q  <= 1'b0;
            res_code_q  <= '0;
            res_value_q <= '0;
          end
          CMD_PAUSE: begin
            res_kind_q  <= KIND_PAUSE;
            res_mask_q  <= '0;
            res_feed_q  <= '0;
            res_has_q   <= 1'b0;
            res_move_q  <= 1'b0;
            res_code_q  <= '0;
            res_value_q <= w1_q;
          end
          CMD_DELAY: begin
            res_kind_q  <= KIND_DWELL;
            res_mask_q  <= '0;
            res_feed_q  <= '0;
            res_has_q   <= 1'b0;
            res_move_q  <= 1'b0;
            res_code_q  <= '0;
            res_value_q <= w1_q;
          end
          CMD_PARAM: begin
            if (w1_q == PARAM_NOZZLE)   res_kind_q <= KIND_NOZZLE;
            else if (w1_q == PARAM_BED) res_kind_q <= KIND_BED;
            else                        res_kind_q <= KIND_REPORT;
            res_mask_q  <= '0;
            res_feed_q  <= '0;
            res_has_q   <= 1'b0;
            res_move_q  <= 1'b0;
            res_code_q  <= w1_q;
            res_value_q <= w2_q;
          end
          CMD_MOVEF: begin
            res_kind_q  <= KIND_MOVE;
            res_move_q  <= 1'b1;
            res_mask_q  <= mf_flags;
            res_has_q   <= rep_has;
            res_feed_q  <= rep_has ? rep_f : '0;
            res_code_q  <= '0;
            res_value_q <= '0;
          end
          CMD_MOVEL: begin
            res_kind_q  <= KIND_MOVE;
            res_move_q  <= 1'b1;
            res_mask_q  <= AXM_MOVEL;
            res_feed_q  <= '0;
            res_has_q   <= 1'b0;
            res_code_q  <= '0;
            res_value_q <= '0;
          end
          default: begin
            res_kind_q  <= KIND_UNKNOWN;
            res_mask_q  <= '0;
            res_feed_q  <= '0;
            res_has_q   <= 1'b0;
            res_move_q  <= 1'b0;
            res_code_q  <= cmd_q;
            res_value_q <= w1_q;
          end
        endcase
      end
      ST_TRI:  if (alu_done) tri_q <= alu_res[31:1];
      ST_MV:   if (alu_done) p1_q <= alu_res[30:0];
      ST_MA: begin
        if (alu_done) begin
          unique case (ax_q)
            AX_X:    sx_q <= steps_new;
            AX_Y:    sy_q <= steps_new;
            default: se_q <= steps_new;
          endcase
        end
      end
      ST_QDIV: if (alu_done) ax_q <= (ax_q == AX_E) ? AX_X : 2'(ax_q + 2'd1);
      ST_CHECK: begin
        if (cnt_n >= 16'd2 && per == 16'd0) begin
          res_has_q  <= rep_has;
          res_feed_q <= rep_has ? rep_f : '0;
        end
      end
      ST_D1:   if (alu_done) tmp_q <= alu_res[31:0];
      ST_D2:   if (alu_done) d_q <= alu_res[47:0];
      ST_FD: begin
        if (alu_done) begin
          if (feed_ax > fmax_q) fmax_q <= feed_ax;
          ax_q <= (ax_q == AX_E) ? AX_X : 2'(ax_q + 2'd1);
        end
      end
      ST_FIN: begin
        res_has_q  <= rep_has;
        res_feed_q <= rep_has ? rep_f : '0;
      end
      default: ;
    endcase

    // result register, positions as they stand after the block
    if (state_q == ST_PUT && slot_free) begin
      kind_o      <= res_kind_q;
      out_x_o     <= res_move_q ? pos_y_q : '0;
      out_y_o     <= res_move_q ? sat32(-{{4{pos_x_q[31]}}, pos_x_q}) : '0;
      out_z_o     <= res_move_q ?
                     sat32({{4{pos_z_q[31]}}, pos_z_q} + {{4{z_off_q[31]}}, z_off_q}) : '0;
      out_e_o     <= res_move_q ? pos_e_q : '0;
      axis_mask_o <= res_mask_q;
      feed_o      <= res_feed_q;
      has_feed_o  <= res_has_q;
      code_o      <= res_code_q;
      value_o     <= res_value_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[sim/print_block_motion_interpreter_checker.sv]
`timescale 1ns / 1ps

module print_block_motion_interpreter_checker
  import pbmi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] command_i,
  input  logic [31:0] word_one_i,
  input  logic [31:0] word_two_i,
  input  logic [31:0] word_three_i,
  input  logic [31:0] word_four_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  kind_i,
  input  logic [31:0] out_x_i,
  input  logic [31:0] out_y_i,
  input  logic [31:0] out_z_i,
  input  logic [31:0] out_e_i,
  input  logic [3:0]  axis_mask_i,
  input  logic [30:0] feed_i,
  input  logic        has_feed_i,
  input  logic [31:0] code_i,
  input  logic [31:0] value_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] e;
    logic [3:0]  mask;
    logic [30:0] feed;
    logic        has;
    logic [31:0] code;
    logic [31:0] value;
  } result_t;

  localparam longint unsigned CAP = 64'h1_0000_0000;
  localparam longint unsigned FMAX = 64'h7FFF_FFFF;

  result_t                result_q[$];
  logic [15:0]            spm_x, spm_y, spm_e;
  logic signed [31:0]     z_off;
  logic [31:0]            ticks;
  logic signed [31:0]     pos_x, pos_y, pos_z, pos_e;
  logic [31:0]            last_feed, peak_feed;
  logic [3:0]             flags;
  logic                   xy_next;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic longint unsigned float_mag(input logic [31:0] w, input int frac,
                                                input logic rnd);
    int              ex;
    longint unsigned m;
    int              sh;
    longint unsigned v;
    ex = int'(w[30:23]);
    m = 64'(w[22:0]);
    if (ex == 255) return (m != 0) ? 0 : CAP;
    if (ex == 0) begin
      if (m == 0) return 0;
      ex = 1;
    end else begin
      m = m | 64'h80_0000;
    end
    sh = ex - 150 + frac;
    if (sh >= 0) begin
      if (sh >= 9) return CAP;
      v = m << sh;
      return (v > CAP) ? CAP : v;
    end
    if (-sh >= 40) return 0;
    return rnd ? (m + (64'd1 << (-sh - 1))) >> (-sh) : m >> (-sh);
  endfunction

  function automatic logic signed [31:0] float_pos(input logic [31:0] w);
    longint mag;
    mag = longint'(float_mag(w, FRAC_BITS, 1'b1));
    return clamp32(w[31] ? -mag : mag);
  endfunction

  function automatic logic [31:0] float_feed(input logic [31:0] w);
    longint unsigned mag;
    mag = float_mag(w, 0, 1'b0);
    return (mag > FMAX) ? 32'(FMAX) : 32'(mag);
  endfunction

  function automatic logic is_nan(input logic [31:0] w);
    return w[30:23] == 8'hFF && w[22:0] != 0;
  endfunction

  function automatic longint ramp(input longint n, input logic [15:0] v,
                                  input logic [15:0] a);
    longint num;
    num = longint'(signed'(v)) * n + longint'(signed'(a)) * ((n * (n - 1)) / 2);
    if (num >= 0) return num / 512;
    return -((-num + 511) / 512);
  endfunction

  function automatic longint steps_q(input longint s, input logic [15:0] spm);
    longint unsigned d;
    longint unsigned mag;
    longint          q;
    d = (spm == 0) ? 1 : 64'(spm);
    mag = 64'(s < 0 ? -s : s) << FRAC_BITS;
    q = longint'((mag + d / 2) / d);
    return s < 0 ? -q : q;
  endfunction

  function automatic logic [31:0] axis_rate(input longint s, input logic [15:0] spm,
                                            input longint n, input longint per);
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] q;
    num = 128'(s < 0 ? -s : s) * 128'd60 * 128'(ticks);
    den = 128'((spm == 0) ? 1 : spm) * 128'(per) * 128'(n);
    q = num / den;
    return (q > 128'(FMAX)) ? 32'(FMAX) : q[31:0];
  endfunction

  function automatic result_t plain(input logic [2:0] kind, input logic [31:0] code,
                                    input logic [31:0] value);
    result_t r;
    r = '0;
    r.kind = kind;
    r.code = code;
    r.value = value;
    return r;
  endfunction

  // fills position fields and, when a feed is given, updates the last reported feed
  task automatic push_move(input logic [3:0] mask, input logic with_feed,
                           input logic [31:0] f);
    result_t r;
    r = '0;
    r.kind = KIND_MOVE;
    r.x = pos_y;
    r.y = clamp32(-longint'(pos_x));
    r.z = clamp32(longint'(pos_z) + longint'(z_off));
    r.e = pos_e;
    r.mask = mask;
    if (with_feed) begin
      r.has = (last_feed != f);
      last_feed = f;
      r.feed = r.has ? f[30:0] : '0;
    end
    result_q.push_back(r);
  endtask

  task automatic predict_block(input logic [31:0] cmd, input logic [31:0] w1,
                               input logic [31:0] w2, input logic [31:0] w3,
                               input logic [31:0] w4);
    logic        xy;
    longint      n, per, sx, sy, se;
    logic [31:0] f, fy, fe;
    case (cmd)
      CMD_STOP:  result_q.push_back(plain(KIND_STOP, 0, 0));
      CMD_PAUSE: result_q.push_back(plain(KIND_PAUSE, 0, w1));
      CMD_DELAY: result_q.push_back(plain(KIND_DWELL, 0, w1));
      CMD_PARAM: result_q.push_back(plain(w1 == PARAM_NOZZLE ? KIND_NOZZLE :
                                          (w1 == PARAM_BED ? KIND_BED : KIND_REPORT),
                                          w1, w2));
      CMD_MOVEF: begin
        xy = xy_next;
        xy_next = !xy;
        if (xy) begin
          flags = '0;
          peak_feed = '0;
        end
        if (w1[30:0] != 0) begin
          f = float_feed(w1);
          if (xy) pos_x = float_pos(w2);
          else pos_z = float_pos(w2);
          if (!is_nan(w1) && f > peak_feed) peak_feed = f;
          flags |= xy ? AXM_X : AXM_Z;
        end
        if (w3[30:0] != 0) begin
          f = float_feed(w3);
          if (xy) pos_y = float_pos(w4);
          else if (w3[31] && !is_nan(w3)) pos_e = float_pos(w4);
          else pos_e = clamp32(longint'(pos_e) + longint'(float_pos(w4)));
          if (!is_nan(w3) && f > peak_feed) peak_feed = f;
          flags |= xy ? AXM_Y : AXM_E;
        end
        if (!xy && flags != 0) push_move(flags, 1'b1, peak_feed);
      end
      CMD_MOVEL: begin
        n = longint'(w1[15:0]);
        per = longint'(w1[31:16]);
        sx = ramp(n, w2[15:0], w3[31:16]);
        sy = ramp(n, w2[31:16], w4[15:0]);
        se = ramp(n, w3[15:0], w4[31:16]);
        pos_x = clamp32(longint'(pos_x) + steps_q(sx, spm_x));
        pos_y = clamp32(longint'(pos_y) + steps_q(sy, spm_y));
        pos_e = clamp32(longint'(pos_e) + steps_q(se, spm_e));
        if (sx != 0 || sy != 0 || se != 0) begin
          f = 32'(FMAX);
          if (n > 1 && per != 0) begin
            f = axis_rate(sx, spm_x, n, per);
            fy = axis_rate(sy, spm_y, n, per);
            fe = axis_rate(se, spm_e, n, per);
            if (fy > f) f = fy;
            if (fe > f) f = fe;
          end
          push_move(AXM_MOVEL, n > 1, f);
        end
      end
      default: result_q.push_back(plain(KIND_UNKNOWN, cmd, w1));
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      result_q.delete();
      spm_x = 16'd854;
      spm_y = 16'd854;
      spm_e = 16'd854;
      z_off = 32'sd8067482;
      ticks = 32'd50000000;
      pos_x = '0;
      pos_y = '0;
      pos_z = '0;
      pos_e = '0;
      last_feed = '1;
      peak_feed = '0;
      flags = '0;
      xy_next = 1'b1;
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SPM_X:    spm_x = cfg_data_i[15:0];
          REG_SPM_Y:    spm_y = cfg_data_i[15:0];
          REG_SPM_E:    spm_e = cfg_data_i[15:0];
          REG_Z_OFFSET: z_off = cfg_data_i;
          REG_TICK:     ticks = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          $error("result word with nothing expected, kind %0d", kind_i);
          fail_count_o++;
        end else begin
          want = result_q.pop_front();
          if (kind_i != want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind_i);
            fail_count_o++;
          end
          if (out_x_i != want.x) begin
            $error("out_x: expected %0h, got %0h", want.x, out_x_i);
            fail_count_o++;
          end
          if (out_y_i != want.y) begin
            $error("out_y: expected %0h, got %0h", want.y, out_y_i);
            fail_count_o++;
          end
          if (out_z_i != want.z) begin
            $error("out_z: expected %0h, got %0h", want.z, out_z_i);
            fail_count_o++;
          end
          if (out_e_i != want.e) begin
            $error("out_e: expected %0h, got %0h", want.e, out_e_i);
            fail_count_o++;
          end
          if (axis_mask_i != want.mask) begin
            $error("axis_mask: expected %0h, got %0h", want.mask, axis_mask_i);
            fail_count_o++;
          end
          if (feed_i != want.feed) begin
            $error("feed: expected %0d, got %0d", want.feed, feed_i);
            fail_count_o++;
          end
          if (has_feed_i != want.has) begin
            $error("has_feed: expected %0d, got %0d", want.has, has_feed_i);
            fail_count_o++;
          end
          if (code_i != want.code) begin
            $error("code: expected %0h, got %0h", want.code, code_i);
            fail_count_o++;
          end
          if (value_i != want.value) begin
            $error("value: expected %0h, got %0h", want.value, value_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_block(command_i, word_one_i, word_two_i, word_three_i, word_four_i);
      end
      pending_o = result_q.size();
    end
  end

endmodule

[sim/print_block_motion_interpreter_test.sv]
`timescale 1ns / 1ps

module print_block_motion_interpreter_test;
  import pbmi_pkg::*;

  // the longest block is a movel with three feeds
  localparam int SETTLE = 1200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] command_i = '0;
  logic [31:0] word_one_i = '0;
  logic [31:0] word_two_i = '0;
  logic [31:0] word_three_i = '0;
  logic [31:0] word_four_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  kind_o;
  logic [31:0] out_x_o, out_y_o, out_z_o, out_e_o;
  logic [3:0]  axis_mask_o;
  logic [30:0] feed_o;
  logic        has_feed_o;
  logic [31:0] code_o, value_o;
  int          fail_count;
  int          pending;
  int          sent;
  // bursts with no idle gaps on each side
  logic        send_burst = 1'b0;
  logic        take_burst = 1'b0;

  always #10 clk_i = ~clk_i;

  print_block_motion_interpreter dut (.*);

  print_block_motion_interpreter_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o),
    .command_i, .word_one_i, .word_two_i, .word_three_i, .word_four_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .kind_i(kind_o), .out_x_i(out_x_o), .out_y_i(out_y_o), .out_z_i(out_z_o),
    .out_e_i(out_e_o), .axis_mask_i(axis_mask_o), .feed_i(feed_o),
    .has_feed_i(has_feed_o), .code_i(code_o), .value_i(value_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // timeout guard, far beyond the slowest legal run
  initial begin
    #100_000_000;
    $display("print_block_motion_interpreter: mismatch");
    $finish;
  end

  // drive one block word; called at a rising edge, returns at its accepting edge
  task automatic send_block(input logic [31:0] cmd, input logic [31:0] w1,
                            input logic [31:0] w2, input logic [31:0] w3,
                            input logic [31:0] w4);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    word_one_i <= w1;
    word_two_i <= w2;
    word_three_i <= w3;
    word_four_i <= w4;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    sent++;
    if (sent % 32 == 0) send_burst = ($urandom_range(0, 3) == 0);
  endtask

  // wait until nothing is owed and the block has had time to finish silent work
  task automatic settle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0 || !in_ready_o) @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic load_config(input logic [15:0] sx, input logic [15:0] sy,
                             input logic [15:0] se, input logic [31:0] zo,
                             input logic [31:0] tk);
    write_reg(REG_SPM_X, 32'(sx));
    write_reg(REG_SPM_Y, 32'(sy));
    write_reg(REG_SPM_E, 32'(se));
    write_reg(REG_Z_OFFSET, zo);
    write_reg(REG_TICK, tk);
    cfg_we_i <= 1'b0;
  endtask

  // float words: mostly modest normals, plus zeros, large normals, specials, subnormals, raw bits
  function automatic logic [31:0] rand_float();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 11))
      0: w = {w[31], 31'd0};
      1: ;
      2: w = {w[31], 8'hFF, ($urandom_range(0, 1) == 0) ? 23'd0 : w[22:0]};
      3: w = {w[31], 8'h00, w[22:0]};
      4: w = {w[31], 8'(8'd150 + $urandom_range(0, 12)), w[22:0]};
      default: w = {w[31], 8'(8'd110 + $urandom_range(0, 40)), w[22:0]};
    endcase
    return w;
  endfunction

  function automatic logic [15:0] rand_short();
    logic [15:0] s;
    s = 16'($urandom());
    if ($urandom_range(0, 2) == 0) s = 16'($signed(s[7:0]));
    return s;
  endfunction

  task automatic send_movel_random();
    logic [15:0] n, per;
    n = 16'($urandom());
    case ($urandom_range(0, 5))
      0: n = 16'($urandom_range(0, 2));
      1, 2: n = 16'($urandom_range(0, 64));
      3: n = 16'($urandom_range(0, 1000));
      default: ;
    endcase
    per = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom());
    send_block(CMD_MOVEL, {per, n}, {rand_short(), rand_short()},
               {rand_short(), rand_short()}, {rand_short(), rand_short()});
  endtask

  // returns the number of block words sent
  task automatic send_random(output int count);
    logic [31:0] w1;
    count = 1;
    w1 = $urandom();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6: begin
        // well formed movef pair
        send_block(CMD_MOVEF, rand_float(), rand_float(), rand_float(), rand_float());
        send_block(CMD_MOVEF, rand_float(), rand_float(), rand_float(), rand_float());
        count = 2;
      end
      7: send_block(CMD_MOVEF, rand_float(), rand_float(), rand_float(), rand_float());
      8, 9, 10, 11, 12: send_movel_random();
      13: send_block(CMD_STOP, $urandom(), $urandom(), $urandom(), $urandom());
      14: send_block(CMD_PAUSE, w1, $urandom(), $urandom(), $urandom());
      15: send_block(CMD_DELAY, w1, $urandom(), $urandom(), $urandom());
      16, 17: begin
        case ($urandom_range(0, 2))
          0: w1 = PARAM_NOZZLE;
          1: w1 = PARAM_BED;
          default: ;
        endcase
        send_block(CMD_PARAM, w1, $urandom(), $urandom(), $urandom());
      end
      18: send_block($urandom_range(0, 1) ? 32'($urandom_range(7, 40)) : $urandom(),
                     w1, $urandom(), $urandom(), $urandom());
      default: send_block(32'd0, w1, $urandom(), $urandom(), $urandom());
    endcase
  endtask

  // result side stalls
  initial begin
    int stall;
    @(posedge clk_i);
    forever begin
      stall = take_burst ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(negedge clk_i);
      while (!out_valid_o) @(negedge clk_i);
      @(posedge clk_i);
      if ($urandom_range(0, 15) == 0) take_burst = ~take_burst;
    end
  end

  initial begin
    int n;
    int got;
    sent = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed blocks on the reset configuration
    send_block(CMD_STOP, '1, '1, '1, '1);
    send_block(CMD_PAUSE, 32'hFFFF_FFFF, '0, '0, '0);
    send_block(CMD_DELAY, 32'd0, '1, '0, '0);
    send_block(CMD_PARAM, PARAM_NOZZLE, 32'd215, '0, '0);
    send_block(CMD_PARAM, PARAM_BED, 32'hFFFF_FFFF, '0, '0);
    send_block(CMD_PARAM, 32'h8000_0001, 32'h1234_5678, '0, '0);
    send_block(32'd0, 32'hDEAD_BEEF, '0, '0, '0);
    send_block(32'hFFFF_FFFF, 32'h0, '0, '0, '0);
    // movef with ordinary values: 10 mm/s, 1.5 mm, 20 mm/s, -2.25 mm
    send_block(CMD_MOVEF, 32'h4120_0000, 32'h3FC0_0000, 32'h41A0_0000, 32'hC010_0000);
    send_block(CMD_MOVEF, 32'h4120_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h4000_0000);
    // same feed again: not reported a second time; negative speed loads e
    send_block(CMD_MOVEF, 32'h0, 32'h0, 32'h41A0_0000, 32'h3F00_0000);
    send_block(CMD_MOVEF, 32'h0, 32'h0, 32'hBF80_0000, 32'hC000_0000);
    // nan speed counts as set but not as feed, infinities saturate
    send_block(CMD_MOVEF, 32'h7FC0_0000, 32'h7F80_0000, 32'hFF80_0000, 32'hFF80_0000);
    send_block(CMD_MOVEF, 32'h7FC0_0001, 32'h0000_0001, 32'h7F80_0000, 32'h7FFF_FFFF);
    // negative zero speeds on both halves give no move
    send_block(CMD_MOVEF, 32'h8000_0000, '1, 32'h8000_0000, '1);
    send_block(CMD_MOVEF, 32'h8000_0000, '1, 32'h8000_0000, '1);
    // movel: count zero, count one, zero period, extreme shorts
    send_block(CMD_MOVEL, {16'd100, 16'd0}, '1, '1, '1);
    send_block(CMD_MOVEL, {16'd100, 16'd1}, 32'h7FFF_8000, 32'h8000_7FFF, '0);
    send_block(CMD_MOVEL, {16'd0, 16'd200}, 32'h0100_0100, 32'h0010_0100, 32'h0010_0010);
    send_block(CMD_MOVEL, {16'hFFFF, 16'hFFFF}, 32'h7FFF_7FFF, 32'h7FFF_7FFF,
               32'h7FFF_7FFF);
    send_block(CMD_MOVEL, {16'd1, 16'hFFFF}, 32'h8000_8000, 32'h8000_8000,
               32'h8000_8000);
    send_block(CMD_MOVEL, {16'd1, 16'd2}, 32'h0000_0100, '0, '0);
    send_block(CMD_MOVEL, {16'd1, 16'd2}, 32'h0000_0100, '0, '0);

    for (int phase = 0; phase < 6; phase++) begin
      settle();
      case (phase)
        0: load_config(16'd1, 16'd1, 16'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        1: load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h8000_0000, 32'd1);
        2: load_config(16'd854, 16'd854, 16'd854, 32'd8067482, 32'd50000000);
        default: load_config(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 4000)),
                             16'($urandom_range(1, 65535)), $urandom(),
                             32'($urandom_range(1, 32'hFFFF_FFFF)));
      endcase
      n = 0;
      while (n < 110) begin
        send_random(got);
        n += got;
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("print_block_motion_interpreter: match");
    end else begin
      $display("print_block_motion_interpreter: mismatch");
    end
    $finish;
  end

endmodule
